// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the pixel pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// The consequent must hold the given delay n after the antecedent.
`define ASSERT_DLY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("delayed check failed");

`endif

// File: sv/isp_cpp_pkg.sv
// Types, constants and the gamma table of the color pixel pipeline.
package isp_cpp_pkg;

  localparam int NumCh = 3;
  localparam int ChanWidth = 8;
  localparam int GainWidth = 10;
  localparam int CfgIndexWidth = 4;
  localparam int CfgDataWidth = 10;
  localparam int ProdWidth = ChanWidth + GainWidth;
  localparam int CoefWidth = 12;
  localparam int MatProdWidth = ChanWidth + 1 + CoefWidth;
  localparam int MatSumWidth = MatProdWidth + 2;
  localparam int MatFracBits = 10;
  localparam int MatQuotWidth = MatSumWidth - MatFracBits;
  localparam int NumKnots = 51;

  localparam logic [CfgIndexWidth-1:0] RegBlackLevel = 4'd0;
  localparam logic [CfgIndexWidth-1:0] RegGainRed = 4'd1;
  localparam logic [CfgIndexWidth-1:0] RegGainGreen = 4'd2;
  localparam logic [CfgIndexWidth-1:0] RegGainBlue = 4'd3;

  localparam int ChRed = 0;
  localparam int ChGreen = 1;
  localparam int ChBlue = 2;

  localparam logic [ChanWidth-1:0] BlackLevelReset = 8'd16;
  localparam logic [GainWidth-1:0] GainRedReset = 10'd535;
  localparam logic [GainWidth-1:0] GainGreenReset = 10'd256;
  localparam logic [GainWidth-1:0] GainBlueReset = 10'd455;

  localparam logic signed [MatSumWidth-1:0] RoundBias = 23'sd512;

  localparam logic signed [CoefWidth-1:0] Ccm [NumCh*NumCh] = '{
    12'sd1566, -12'sd360, -12'sd182,
    -12'sd290, 12'sd1711, -12'sd397,
    12'sd17, -12'sd586, 12'sd1592
  };

  localparam int unsigned LastSpan = 2047;

  localparam logic [0:NumKnots-1][15:0] KnotX = {
    16'd0, 16'd512, 16'd1024, 16'd1536, 16'd2048, 16'd2560, 16'd3072, 16'd3584,
    16'd4096, 16'd4608, 16'd5120, 16'd5632, 16'd6144, 16'd6656, 16'd7168,
    16'd7680, 16'd8192, 16'd9216, 16'd10240, 16'd11264, 16'd12288, 16'd13312,
    16'd14336, 16'd15360, 16'd16384, 16'd17408, 16'd18432, 16'd19456,
    16'd20480, 16'd22528, 16'd24576, 16'd26624, 16'd28672, 16'd30720,
    16'd32768, 16'd34816, 16'd36864, 16'd38912, 16'd40960, 16'd43008,
    16'd45056, 16'd47104, 16'd49152, 16'd51200, 16'd53248, 16'd55296,
    16'd57344, 16'd59392, 16'd61440, 16'd63488, 16'd65535
  };

  localparam logic [0:NumKnots-1][15:0] KnotY = {
    16'd0, 16'd2518, 16'd5033, 16'd7175, 16'd9309, 16'd10814, 16'd12312,
    16'd13773, 16'd15225, 16'd16566, 16'd17899, 16'd19221, 16'd20534,
    16'd21684, 16'd22826, 16'd24024, 16'd25212, 16'd27251, 16'd29167,
    16'd30947, 16'd32696, 16'd34309, 16'd35849, 16'd37194, 16'd38445,
    16'd39598, 16'd40732, 16'd41717, 16'd42687, 16'd44343, 16'd45871,
    16'd47222, 16'd48441, 16'd49460, 16'd50470, 16'd51476, 16'd52480,
    16'd53382, 16'd54294, 16'd55155, 16'd56035, 16'd56920, 16'd57824,
    16'd58737, 16'd59666, 16'd60604, 16'd61558, 16'd62529, 16'd63516,
    16'd64519, 16'd65535
  };

  typedef logic [NumCh-1:0][ChanWidth-1:0] pixel_t;

  typedef struct packed {
    logic [ChanWidth-1:0] black_level;
    logic [NumCh-1:0][GainWidth-1:0] gain;
  } cfg_t;

  typedef logic [255:0][ChanWidth-1:0] gamma_rom_t;

  // One table entry: linear interpolation of the knot curve at code * 257.
  function automatic logic [ChanWidth-1:0] gamma_entry(input int unsigned code);
    int unsigned pos;
    int unsigned k;
    int unsigned j;
    int unsigned x0;
    int unsigned x1;
    int unsigned y0;
    int unsigned y1;
    int unsigned span;
    int unsigned prod;
    int unsigned quo;
    int unsigned v;
    int unsigned o;
    pos = code * 257;
    k = 0;
    for (j = 1; j < NumKnots - 1; j++) begin
      if (32'(KnotX[j]) < pos) begin
        k = j;
      end
    end
    x0 = 32'(KnotX[k]);
    x1 = 32'(KnotX[k+1]);
    y0 = 32'(KnotY[k]);
    y1 = 32'(KnotY[k+1]);
    span = x1 - x0;
    prod = (y1 - y0) * (pos - x0);
    if (span == LastSpan) begin
      quo = prod / LastSpan;
    end else begin
      quo = prod;
      while (span > 1) begin
        quo = quo >> 1;
        span = span >> 1;
      end
    end
    v = y0 + quo;
    o = (v + 128) >> 8;
    if (o > 255) begin
      o = 255;
    end
    return o[ChanWidth-1:0];
  endfunction

  function automatic gamma_rom_t build_gamma();
    gamma_rom_t rom;
    for (int i = 0; i < 256; i++) begin
      rom[i] = gamma_entry(i);
    end
    return rom;
  endfunction

  localparam gamma_rom_t GammaRom = build_gamma();

endpackage

// File: sv/isp_color_pixel_pipeline_top.sv
// Top level of the color pixel pipeline: black level, gains, matrix, gamma.
// The pipeline takes one pixel in every clock cycle and never raises busy.
// A pixel transferred with start appears on the outputs with a one-cycle done
// pulse after the five register stages, which are the pedestal subtraction,
// the gain multiply, the matrix multiply, the matrix sum with rounding and
// clipping, and the gamma table lookup. Results cannot be held off, so the
// receiver must take each one in the cycle that done is high.
// Register writes take effect at the next clock edge and should only be made
// while no pixel is in flight.
module isp_color_pixel_pipeline_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [isp_cpp_pkg::ChanWidth-1:0]     red_in,
  input  logic [isp_cpp_pkg::ChanWidth-1:0]     green_in,
  input  logic [isp_cpp_pkg::ChanWidth-1:0]     blue_in,
  output logic                                  done,
  output logic [isp_cpp_pkg::ChanWidth-1:0]     red_out,
  output logic [isp_cpp_pkg::ChanWidth-1:0]     green_out,
  output logic [isp_cpp_pkg::ChanWidth-1:0]     blue_out,
  input  logic                                  wr_en,
  input  logic [isp_cpp_pkg::CfgIndexWidth-1:0] wr_index,
  input  logic [isp_cpp_pkg::CfgDataWidth-1:0]  wr_data
);
  import isp_cpp_pkg::*;

  cfg_t cfg;
  pixel_t pix_in;
  pixel_t pix_wb;
  pixel_t pix_ccm;
  pixel_t pix_out;
  logic valid_wb;
  logic valid_ccm;

  assign busy = 1'b0;

  assign pix_in[ChRed] = red_in;
  assign pix_in[ChGreen] = green_in;
  assign pix_in[ChBlue] = blue_in;

  isp_cpp_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  isp_cpp_wb u_wb (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start && !busy),
    .pix_in    (pix_in),
    .cfg       (cfg),
    .valid_out (valid_wb),
    .pix_out   (pix_wb)
  );

  isp_cpp_ccm u_ccm (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (valid_wb),
    .pix_in    (pix_wb),
    .valid_out (valid_ccm),
    .pix_out   (pix_ccm)
  );

  isp_cpp_gamma u_gamma (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (valid_ccm),
    .pix_in    (pix_ccm),
    .valid_out (done),
    .pix_out   (pix_out)
  );

  assign red_out = pix_out[ChRed];
  assign green_out = pix_out[ChGreen];
  assign blue_out = pix_out[ChBlue];

endmodule

// File: sv/isp_cpp_regs.sv
// Configuration register file: black level and white balance gains.
module isp_cpp_regs (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     wr_en,
  input  logic [isp_cpp_pkg::CfgIndexWidth-1:0]    wr_index,
  input  logic [isp_cpp_pkg::CfgDataWidth-1:0]     wr_data,
  output isp_cpp_pkg::cfg_t                        cfg
);
  import isp_cpp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.black_level <= BlackLevelReset;
      cfg.gain[ChRed] <= GainRedReset;
      cfg.gain[ChGreen] <= GainGreenReset;
      cfg.gain[ChBlue] <= GainBlueReset;
    end else if (wr_en) begin
      case (wr_index)
        RegBlackLevel: cfg.black_level <= wr_data[ChanWidth-1:0];
        RegGainRed:    cfg.gain[ChRed] <= wr_data[GainWidth-1:0];
        RegGainGreen:  cfg.gain[ChGreen] <= wr_data[GainWidth-1:0];
        RegGainBlue:   cfg.gain[ChBlue] <= wr_data[GainWidth-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/isp_cpp_wb.sv
// Black level subtraction and white balance gain, two register stages.
module isp_cpp_wb (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  isp_cpp_pkg::pixel_t pix_in,
  input  isp_cpp_pkg::cfg_t   cfg,
  output logic                valid_out,
  output isp_cpp_pkg::pixel_t pix_out
);
  import isp_cpp_pkg::*;

  logic valid_s1;
  logic valid_s2;
  pixel_t level;
  logic [NumCh-1:0][ProdWidth-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid_s2 <= 1'b0;
    end else begin
      valid_s1 <= valid_in;
      valid_s2 <= valid_s1;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NumCh; c++) begin
      level[c] <= (pix_in[c] > cfg.black_level) ? pix_in[c] - cfg.black_level : '0;
      prod[c] <= ProdWidth'(level[c]) * ProdWidth'(cfg.gain[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      pix_out[c] = (|prod[c][ProdWidth-1:ChanWidth+8]) ? '1 : prod[c][ChanWidth+7:8];
    end
  end

  assign valid_out = valid_s2;

endmodule

// File: sv/isp_cpp_ccm.sv
// Fixed 3x3 color matrix: a product stage and a sum, round and clip stage.
module isp_cpp_ccm (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  isp_cpp_pkg::pixel_t pix_in,
  output logic                valid_out,
  output isp_cpp_pkg::pixel_t pix_out
);
  import isp_cpp_pkg::*;

  logic valid_s1;
  logic signed [MatProdWidth-1:0] prod [NumCh][NumCh];
  logic signed [MatSumWidth-1:0] sum [NumCh];
  logic signed [MatQuotWidth-1:0] quot [NumCh];
  pixel_t clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      valid_s1 <= valid_in;
      valid_out <= valid_s1;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < NumCh; r++) begin
      for (int c = 0; c < NumCh; c++) begin
        prod[r][c] <= $signed({1'b0, pix_in[c]}) * Ccm[r*NumCh+c];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < NumCh; r++) begin
      sum[r] = RoundBias + MatSumWidth'(prod[r][ChRed]) + MatSumWidth'(prod[r][ChGreen])
               + MatSumWidth'(prod[r][ChBlue]);
      quot[r] = MatQuotWidth'(sum[r] >>> MatFracBits);
      if (quot[r] < 0) begin
        clip[r] = '0;
      end else if (quot[r] > $signed(MatQuotWidth'(255))) begin
        clip[r] = '1;
      end else begin
        clip[r] = quot[r][ChanWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    pix_out <= clip;
  end

endmodule

// File: sv/isp_cpp_gamma.sv
// Gamma lookup for the three channels from the constant curve table.
module isp_cpp_gamma (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  isp_cpp_pkg::pixel_t pix_in,
  output logic                valid_out,
  output isp_cpp_pkg::pixel_t pix_out
);
  import isp_cpp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NumCh; c++) begin
      pix_out[c] <= GammaRom[pix_in[c]];
    end
  end

endmodule

// File: sv/isp_cpp_checker.sv
// Port-level checks of the color pixel pipeline and their binding.
`include "assert_macros.svh"

module isp_cpp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Every transfer is followed by a result on done.
  `ASSERT_DLY(a_latency, clk, rst, start && !busy, 5, done)

  // No result appears without an earlier transfer.
  `ASSERT_IMP(a_no_spurious, clk, rst, done, $past(start && !busy, 5))

  // The pipeline accepts a pixel in every cycle.
  `ASSERT_IMP(a_never_busy, clk, rst, 1'b1, !busy)

endmodule

bind isp_color_pixel_pipeline_top isp_cpp_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// File: bench/tb_isp_color_pixel_pipeline_top.sv
// Self-checking testbench for the color pixel pipeline with a built-in predictor.
`timescale 1ns / 100ps

module tb_isp_color_pixel_pipeline_top;
  import isp_cpp_pkg::*;

  localparam int PipeLatency = 5;
  localparam int CycleLimit = 200000;
  localparam int NumPhases = 8;
  localparam int PixelsPerPhase = 160;
  localparam int NumDirected = 25;
  localparam int MaxGain = (1 << GainWidth) - 1;
  localparam int MaxLevel = (1 << ChanWidth) - 1;
  localparam logic [CfgIndexWidth-1:0] RegFirstSpare = CfgIndexWidth'(RegGainBlue + 1);
  localparam logic [CfgIndexWidth-1:0] RegLastSpare = '1;
  // Shares its low two bits with gain_blue, so a decoder that ignores the
  // upper index bits would overwrite that gain.
  localparam logic [CfgIndexWidth-1:0] RegAliasBlue = 4'd7;

  localparam int unsigned CurveX [NumKnots] = '{
    0, 512, 1024, 1536, 2048, 2560, 3072, 3584, 4096, 4608,
    5120, 5632, 6144, 6656, 7168, 7680, 8192, 9216, 10240, 11264,
    12288, 13312, 14336, 15360, 16384, 17408, 18432, 19456, 20480, 22528,
    24576, 26624, 28672, 30720, 32768, 34816, 36864, 38912, 40960, 43008,
    45056, 47104, 49152, 51200, 53248, 55296, 57344, 59392, 61440, 63488,
    65535
  };
  localparam int unsigned CurveY [NumKnots] = '{
    0, 2518, 5033, 7175, 9309, 10814, 12312, 13773, 15225, 16566,
    17899, 19221, 20534, 21684, 22826, 24024, 25212, 27251, 29167, 30947,
    32696, 34309, 35849, 37194, 38445, 39598, 40732, 41717, 42687, 44343,
    45871, 47222, 48441, 49460, 50470, 51476, 52480, 53382, 54294, 55155,
    56035, 56920, 57824, 58737, 59666, 60604, 61558, 62529, 63516, 64519,
    65535
  };
  localparam int ColorMatrix [NumCh*NumCh] = '{
    1566, -360, -182,
    -290, 1711, -397,
    17, -586, 1592
  };

  typedef enum logic {RowWrite, RowPixel} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0] data;
    pixel_t px;
    bit typed;
    pixel_t want;
  } step_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [ChanWidth-1:0] red_in = '0;
  logic [ChanWidth-1:0] green_in = '0;
  logic [ChanWidth-1:0] blue_in = '0;
  logic done;
  logic [ChanWidth-1:0] red_out;
  logic [ChanWidth-1:0] green_out;
  logic [ChanWidth-1:0] blue_out;
  logic wr_en = 1'b0;
  logic [CfgIndexWidth-1:0] wr_index = '0;
  logic [CfgDataWidth-1:0] wr_data = '0;

  logic [ChanWidth-1:0] black_lvl = BlackLevelReset;
  logic [GainWidth-1:0] wb_gain [NumCh] = '{GainRedReset, GainGreenReset, GainBlueReset};

  pixel_t pending_pixels [$];
  int errors = 0;
  int cycles = 0;

  // Pixels are written {blue, green, red}.
  step_t directed_steps [NumDirected] = '{
    '{RowPixel, RegBlackLevel, '0, {8'd0, 8'd0, 8'd0}, 1'b1, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd16, 8'd16, 8'd16}, 1'b1, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd0, 8'd3, 8'd15}, 1'b1, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd255, 8'd255, 8'd255}, 1'b0, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd128, 8'd128, 8'd128}, 1'b0, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd0, 8'd0, 8'd255}, 1'b0, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd0, 8'd255, 8'd0}, 1'b0, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd255, 8'd0, 8'd0}, 1'b0, '0},
    '{RowPixel, RegBlackLevel, '0, {8'hAA, 8'h55, 8'hAA}, 1'b0, '0},
    '{RowWrite, RegBlackLevel, 10'd0, '0, 1'b0, '0},
    '{RowWrite, RegGainRed, 10'd1023, '0, 1'b0, '0},
    '{RowWrite, RegGainGreen, 10'd1023, '0, 1'b0, '0},
    '{RowWrite, RegGainBlue, 10'd1023, '0, 1'b0, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd255, 8'd255, 8'd255}, 1'b1, '1},
    '{RowPixel, RegBlackLevel, '0, {8'd0, 8'd0, 8'd0}, 1'b1, '0},
    '{RowPixel, RegBlackLevel, '0, {8'h55, 8'hAA, 8'hFF}, 1'b0, '0},
    '{RowWrite, RegAliasBlue, 10'd0, '0, 1'b0, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd255, 8'd255, 8'd255}, 1'b1, '1},
    '{RowWrite, RegGainRed, 10'd0, '0, 1'b0, '0},
    '{RowWrite, RegGainGreen, 10'd0, '0, 1'b0, '0},
    '{RowWrite, RegGainBlue, 10'd0, '0, 1'b0, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd255, 8'd255, 8'd255}, 1'b1, '0},
    '{RowWrite, RegBlackLevel, 10'h3FF, '0, 1'b0, '0},
    '{RowWrite, RegGainRed, 10'd1023, '0, 1'b0, '0},
    '{RowPixel, RegBlackLevel, '0, {8'd255, 8'd255, 8'd255}, 1'b1, '0}
  };

  isp_color_pixel_pipeline_top i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .done(done),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [ChanWidth-1:0] gamma_code(input int unsigned code);
    int unsigned pos;
    int unsigned k;
    int unsigned v;
    int unsigned o;
    pos = code * 257;
    k = 0;
    while (k + 1 < NumKnots - 1 && CurveX[k+1] < pos) begin
      k++;
    end
    if (CurveX[k+1] <= CurveX[k] || pos < CurveX[k] || CurveY[k+1] < CurveY[k]) begin
      v = CurveY[k];
    end else begin
      v = CurveY[k] + ((CurveY[k+1] - CurveY[k]) * (pos - CurveX[k])) /
          (CurveX[k+1] - CurveX[k]);
    end
    o = (v + 128) >> 8;
    if (o > 255) begin
      o = 255;
    end
    return o[ChanWidth-1:0];
  endfunction

  function automatic pixel_t color_correct(input pixel_t px);
    int wb [NumCh];
    int acc;
    int q;
    pixel_t res;
    for (int ch = 0; ch < NumCh; ch++) begin
      wb[ch] = (px[ch] > black_lvl) ? int'(px[ch]) - int'(black_lvl) : 0;
      wb[ch] = (wb[ch] * int'(wb_gain[ch])) >> 8;
      if (wb[ch] > 255) begin
        wb[ch] = 255;
      end
    end
    for (int row = 0; row < NumCh; row++) begin
      acc = 512;
      for (int i = 0; i < NumCh; i++) begin
        acc += ColorMatrix[row*NumCh+i] * wb[i];
      end
      q = acc >>> MatFracBits;
      if (q < 0) begin
        q = 0;
      end
      if (q > 255) begin
        q = 255;
      end
      res[row] = gamma_code(q);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] index,
                           input logic [CfgDataWidth-1:0] data);
    wr_en <= 1'b1;
    wr_index <= index;
    wr_data <= data;
    case (index)
      RegBlackLevel: black_lvl = data[ChanWidth-1:0];
      RegGainRed: wb_gain[ChRed] = data[GainWidth-1:0];
      RegGainGreen: wb_gain[ChGreen] = data[GainWidth-1:0];
      RegGainBlue: wb_gain[ChBlue] = data[GainWidth-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input pixel_t px, input int gap, input bit typed,
                            input pixel_t want);
    wr_en <= 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    red_in <= px[ChRed];
    green_in <= px[ChGreen];
    blue_in <= px[ChBlue];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_pixels.push_back(typed ? want : color_correct(px));
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CfgDataWidth-1:0] pick_setting(input int unsigned hi,
                                                          input int unsigned lo_typ,
                                                          input int unsigned hi_typ);
    case ($urandom_range(7, 0))
      0: return '0;
      1: return CfgDataWidth'(hi);
      2, 3: return CfgDataWidth'($urandom_range(hi, 0));
      default: return CfgDataWidth'($urandom_range(hi_typ, lo_typ));
    endcase
  endfunction

  function automatic logic [ChanWidth-1:0] pick_channel(input int mode);
    int lvl;
    case (mode)
      0: return $urandom_range(1, 0) ? 8'd255 : 8'd0;
      1: begin
        lvl = int'(black_lvl) + int'($urandom_range(4, 0)) - 2;
        if (lvl < 0) begin
          lvl = 0;
        end
        if (lvl > MaxLevel) begin
          lvl = MaxLevel;
        end
        return lvl[ChanWidth-1:0];
      end
      default: return ChanWidth'($urandom_range(MaxLevel, 0));
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result transfer with nothing expected: %0d %0d %0d",
                                  red_out, green_out, blue_out));
      end else begin
        exp_px = pending_pixels.pop_front();
        if (red_out !== exp_px[ChRed]) begin
          report_mismatch($sformatf("red_out %0d, expected %0d", red_out, exp_px[ChRed]));
        end
        if (green_out !== exp_px[ChGreen]) begin
          report_mismatch($sformatf("green_out %0d, expected %0d",
                                    green_out, exp_px[ChGreen]));
        end
        if (blue_out !== exp_px[ChBlue]) begin
          report_mismatch($sformatf("blue_out %0d, expected %0d", blue_out, exp_px[ChBlue]));
        end
      end
    end
  end

  initial begin
    bit no_idle;
    int mode;
    pixel_t px;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == RowWrite) begin
        drain_pipeline();
        write_reg(directed_steps[i].index, directed_steps[i].data);
      end else begin
        send_pixel(directed_steps[i].px, $urandom_range(4, 0), directed_steps[i].typed,
                   directed_steps[i].want);
      end
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_pipeline();
      if (phase == 0) begin
        write_reg(RegBlackLevel, CfgDataWidth'(BlackLevelReset));
        write_reg(RegGainRed, GainRedReset);
        write_reg(RegGainGreen, GainGreenReset);
        write_reg(RegGainBlue, GainBlueReset);
      end else begin
        // The upper data bits are outside black_level and must be dropped.
        write_reg(RegBlackLevel, pick_setting(MaxLevel, 0, 40) |
                  CfgDataWidth'($urandom_range(3, 0) << ChanWidth));
        write_reg(RegGainRed, pick_setting(MaxGain, 200, 640));
        write_reg(RegGainGreen, pick_setting(MaxGain, 200, 640));
        write_reg(RegGainBlue, pick_setting(MaxGain, 200, 640));
      end
      write_reg(CfgIndexWidth'($urandom_range(RegLastSpare, RegFirstSpare)),
                CfgDataWidth'($urandom_range(MaxGain, 0)));
      no_idle = (phase % 3 == 1);
      for (int n = 0; n < PixelsPerPhase; n++) begin
        mode = $urandom_range(9, 0);
        for (int ch = 0; ch < NumCh; ch++) begin
          px[ch] = pick_channel(mode);
        end
        send_pixel(px, no_idle ? 0 : $urandom_range(4, 0), 1'b0, '0);
      end
    end

    drain_pipeline();
    repeat (PipeLatency + 3) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
